// ===== rtl/bpt_pkg.sv =====
// Shared types, constants and helpers for the burst penalty tracker.
// No dependencies; every other file of the block but bpt_ram imports it.
package bpt_pkg;

    localparam int TASK_SLOTS_DEF = 64;
    localparam int FRACTION_BITS  = 12;

    localparam int SLOT_W    = 6;
    localparam int DELTA_W   = 32;
    localparam int NICE_W    = 6;
    localparam int PEN_W     = 18;
    localparam int SCORE_W   = 6;
    localparam int PRIO_W    = 6;
    localparam int COUNT_W   = 6;
    localparam int RUN_W     = 64;
    localparam int LZ_W      = 6;
    localparam int EXP_W     = 7;
    localparam int GREED_W   = EXP_W + FRACTION_BITS;
    localparam int OFFSET_W  = 6;
    localparam int SCALE_W   = 12;
    localparam int LIMIT_W   = 6;
    localparam int PROD_W    = GREED_W + SCALE_W;
    localparam int SCALE_SHIFT = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [PEN_W-1:0]  MAX_PENALTY = PEN_W'((40 << FRACTION_BITS) - 1);
    localparam logic [PRIO_W-1:0] MAX_PRIO    = PRIO_W'(39);

    localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(25);
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(3180);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(40);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ACT_ACCOUNT = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_CLONE   = 2'd2,
        ACT_RESET   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_NORM,
        ST_MUL,
        ST_CAP,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SCALE_W-1:0]  scale;
        logic [LIMIT_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        t_action             action;
        logic                in_range;
        logic [SLOT_W-1:0]   slot;
        logic [DELTA_W-1:0]  delta;
        logic [NICE_W-1:0]   nice;
        logic                kthread;
        logic [PEN_W-1:0]    inh;
    } t_req;

    typedef struct packed {
        logic [RUN_W-1:0]   run_time;
        logic [PEN_W-1:0]   smoothed;
        logic [PEN_W-1:0]   current;
        logic [PEN_W-1:0]   effective;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
    } t_rec;

    localparam t_rec REC_RESET = '{
        run_time:  '0,
        smoothed:  '0,
        current:   '0,
        effective: '0,
        score:     '0,
        count:     COUNT_W'(1)
    };

    function automatic logic [PRIO_W-1:0] prio_of(input logic [NICE_W-1:0] nice,
                                                 input logic [SCORE_W-1:0] score);
        logic [NICE_W:0] sum;
        sum = {1'b0, nice} + {1'b0, score};
        return (sum > {1'b0, MAX_PRIO}) ? MAX_PRIO : sum[PRIO_W-1:0];
    endfunction

endpackage

// ===== rtl/bpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the burst averaging.
// Depends on bpt_pkg for the penalty and count widths.
module bpt_div import bpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PEN_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [PEN_W-1:0]   o_quot,
    output logic [COUNT_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(PEN_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PEN_W-1:0]   r_quot;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [COUNT_W:0]   trial;
    logic               fits;

    assign trial = {r_rem, r_quot[PEN_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PEN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            // a zero count divides as one
            r_div  <= (i_divisor == '0) ? COUNT_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[PEN_W-2:0], fits};
            r_rem  <= fits ? COUNT_W'(trial - {1'b0, r_div}) : trial[COUNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/bpt_front.sv =====
// Front end: accepts requests, classifies slot range, saturates the inherited
// penalty and buffers up to two requests for the back end. Uses bpt_pkg.
module bpt_front import bpt_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [SLOT_W-1:0]  i_task_slot,
    input  logic [DELTA_W-1:0] i_delta_time,
    input  logic [NICE_W-1:0]  i_nice_index,
    input  logic               i_is_kernel_thread,
    input  logic [PEN_W-1:0]   i_inherited_penalty,
    input  logic               i_clearing,
    output logic               o_head_valid,
    output t_req               o_head,
    input  logic               i_pop
);

    t_req       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    t_req       req;
    logic       push;

    always_comb begin
        req.action   = t_action'(i_action);
        req.in_range = 32'(i_task_slot) < 32'(TASK_SLOTS);
        req.slot     = i_task_slot;
        req.delta    = i_delta_time;
        req.nice     = i_nice_index;
        req.kthread  = i_is_kernel_thread;
        req.inh      = (i_inherited_penalty > MAX_PENALTY) ? MAX_PENALTY
                                                           : i_inherited_penalty;
    end

    // hold off requests while the table is being cleared
    assign o_in_ready   = (r_cnt != 2'd2) && !i_clearing;
    assign push         = i_in_valid && o_in_ready;
    assign o_head_valid = r_cnt != 2'd0;
    assign o_head       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= req;
        end
    end

endmodule

// ===== rtl/bpt_back.sv =====
// Back end: sequences one request at a time through table read, log2,
// scaling, averaging divide and write back. Uses bpt_pkg, bpt_ram, bpt_div.
module bpt_back import bpt_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_head_valid,
    input  t_req               i_head,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PEN_W-1:0]   o_penalty_out,
    output logic [SCORE_W-1:0] o_score_out,
    output logic [PRIO_W-1:0]  o_effective_priority,
    output logic               o_priority_changed
);

    localparam int AW    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int REC_W = $bits(t_rec);

    t_state             r_state, n_state;
    t_req               r_req;
    t_rec               r_rec;
    logic [SCORE_W-1:0] r_old_score;
    logic [RUN_W-1:0]   r_norm;
    logic [LZ_W-1:0]    r_lz;
    logic [2:0]         r_step;
    logic [PROD_W-1:0]  r_prod;
    logic               r_up;
    logic [AW-1:0]      r_clr_cnt;
    logic               r_out_valid;
    logic [PEN_W-1:0]   r_out_pen;
    logic [SCORE_W-1:0] r_out_score;
    logic [PRIO_W-1:0]  r_out_prio;
    logic               r_out_chg;

    logic               div_start, div_done, ram_we, out_load;
    logic [PEN_W-1:0]   div_dividend, div_quot;
    logic [COUNT_W-1:0] div_divisor, div_rem;
    logic [REC_W-1:0]   ram_rdata;
    t_rec               rd_rec, wr_rec, ld_rec;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [AW-1:0]      addr;

    logic [RUN_W:0]     run_sum;
    logic [RUN_W-1:0]   run_sat;
    logic [6:0]         sh;
    logic [RUN_W-1:0]   hi_mask;
    logic [EXP_W-1:0]   expo;
    logic [GREED_W-1:0] greed, tol, pen_raw;
    logic [PROD_W-1:0]  scaled;
    logic [PEN_W-1:0]   cap_cur;
    logic [PEN_W-1:0]   step_pen, sm_new, clone_pen;
    logic [LIMIT_W-1:0] lim;
    logic [COUNT_W-1:0] cnt_next;
    logic [SCORE_W-1:0] new_score;

    assign slot_ext = {AW'(0), r_req.slot};
    assign addr     = slot_ext[AW-1:0];
    assign rd_rec   = t_rec'(ram_rdata);

    bpt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ((r_state == ST_CLEAR) ? r_clr_cnt : addr),
        .i_wdata (REC_W'(wr_rec)),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    bpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // datapath helpers
    always_comb begin
        run_sum   = {1'b0, rd_rec.run_time} + (RUN_W + 1)'(r_req.delta);
        // saturate run time at all ones
        run_sat   = run_sum[RUN_W] ? {RUN_W{1'b1}} : run_sum[RUN_W-1:0];
        ld_rec    = rd_rec;
        if (r_req.action == ACT_ACCOUNT) begin
            ld_rec.run_time = run_sat;
        end
        sh        = 7'd32 >> r_step;
        hi_mask   = ~({RUN_W{1'b1}} >> sh);
        expo      = EXP_W'(64) - EXP_W'(r_lz);
        greed     = (r_rec.run_time == '0) ? '0
                  : {expo, r_norm[RUN_W-2 -: FRACTION_BITS]};
        tol       = GREED_W'({i_cfg.offset, {FRACTION_BITS{1'b0}}});
        pen_raw   = (greed > tol) ? greed - tol : '0;
        scaled    = r_prod >> SCALE_SHIFT;
        cap_cur   = (scaled > PROD_W'(MAX_PENALTY)) ? MAX_PENALTY : PEN_W'(scaled);
        step_pen  = div_quot + PEN_W'(div_rem != '0);
        sm_new    = r_up ? r_rec.smoothed + step_pen : r_rec.smoothed - step_pen;
        clone_pen = (sm_new > r_req.inh) ? sm_new : r_req.inh;
        lim       = (i_cfg.limit == '0) ? LIMIT_W'(1) : i_cfg.limit;
        cnt_next  = (r_rec.count < lim) ? r_rec.count + COUNT_W'(1) : lim;
        new_score = r_req.kthread ? '0 : SCORE_W'(r_rec.effective >> FRACTION_BITS);

        if (r_state == ST_LOAD) begin
            div_dividend = (rd_rec.current > rd_rec.smoothed)
                         ? rd_rec.current - rd_rec.smoothed
                         : rd_rec.smoothed - rd_rec.current;
            div_divisor  = rd_rec.count;
        end else begin
            div_dividend = cap_cur - r_rec.smoothed;
            div_divisor  = r_rec.count;
        end

        if (r_state == ST_CLEAR) begin
            wr_rec = REC_RESET;
        end else begin
            wr_rec       = r_rec;
            wr_rec.score = new_score;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_clr_cnt == AW'(TASK_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_head.in_range ? ST_READ : ST_FINISH;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                unique case (r_req.action) inside
                    ACT_ACCOUNT: n_state = ST_NORM;
                    ACT_RESTART, ACT_CLONE: begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                    ACT_RESET: n_state = ST_FINISH;
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_NORM: begin
                if (r_step == 3'd5) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_CAP;
            ST_CAP: begin
                if (cap_cur > r_rec.smoothed) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    ram_we   = r_req.in_range;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_req <= i_head;
            end
            ST_LOAD: begin
                r_old_score <= rd_rec.score;
                r_up        <= rd_rec.current > rd_rec.smoothed;
                r_lz        <= '0;
                r_step      <= '0;
                if (r_req.action == ACT_RESET) begin
                    r_rec <= REC_RESET;
                end else begin
                    r_rec <= ld_rec;
                    if (r_req.action == ACT_ACCOUNT) begin
                        r_norm <= run_sat;
                    end
                end
            end
            ST_NORM: begin
                if ((r_norm & hi_mask) == '0) begin
                    r_norm <= r_norm << sh;
                    r_lz   <= r_lz + LZ_W'(sh);
                end
                r_step <= r_step + 3'd1;
            end
            ST_MUL: begin
                r_prod <= PROD_W'(pen_raw) * PROD_W'(i_cfg.scale);
            end
            ST_CAP: begin
                r_rec.current <= cap_cur;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_req.action == ACT_ACCOUNT) begin
                        r_rec.effective <= r_rec.smoothed + div_quot;
                    end else begin
                        r_rec.run_time <= '0;
                        r_rec.current  <= '0;
                        if (r_req.action == ACT_CLONE) begin
                            r_rec.smoothed  <= clone_pen;
                            r_rec.effective <= clone_pen;
                            r_rec.count     <= COUNT_W'(1);
                        end else begin
                            r_rec.smoothed  <= sm_new;
                            r_rec.effective <= sm_new;
                            r_rec.count     <= cnt_next;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    if (r_req.in_range) begin
                        r_out_pen   <= r_rec.effective;
                        r_out_score <= new_score;
                        r_out_prio  <= prio_of(r_req.nice, new_score);
                        r_out_chg   <= prio_of(r_req.nice, new_score)
                                    != prio_of(r_req.nice, r_old_score);
                    end else begin
                        r_out_pen   <= '0;
                        r_out_score <= '0;
                        r_out_prio  <= prio_of(r_req.nice, '0);
                        r_out_chg   <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_clearing           = r_state == ST_CLEAR;
    assign o_out_valid          = r_out_valid;
    assign o_penalty_out        = r_out_pen;
    assign o_score_out          = r_out_score;
    assign o_effective_priority = r_out_prio;
    assign o_priority_changed   = r_out_chg;

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during table clear");

    a_div_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV))
        else $error("divider started outside the divide step");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("result appeared without finishing a request");

    a_prio_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_prio <= MAX_PRIO && r_out_score <= MAX_PRIO))
        else $error("priority or score out of range");
`endif

endmodule

// ===== rtl/burst_penalty_tracker.sv =====
// Burst penalty tracker: a per-slot burst record table with penalty update.
// Request channel (i_in_valid/o_in_ready) carries one action per request;
// result channel (o_out_valid/i_out_ready) returns one result per request,
// in order. A two-entry queue sits between the request side and the
// sequencer, and a result register sits on the output, so a stalled receiver
// does not block accepting requests until both fill.
// Steps per request, set by the sequencer and the bit-per-cycle divider: an
// account action that raises the penalty runs 6 normalize steps, multiply,
// cap and an 18-step divide; one that does not stops after the cap; restart
// and clone run the 18-step divide; a slot reset reads and rewrites the
// slot, and a slot outside the table goes straight to its result. One
// request is worked at a time. After reset the table is cleared one slot per
// cycle, all TASK_SLOTS slots (64 by default); o_in_ready stays low during
// that pass. Configuration is a plain write port (i_cfg_wr_en, i_cfg_index,
// i_cfg_wdata), written by the user only while no request is in flight; the
// block itself does not enforce this. Depends on bpt_pkg, bpt_front, bpt_back.
module burst_penalty_tracker import bpt_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [SLOT_W-1:0]    i_task_slot,
    input  logic [DELTA_W-1:0]   i_delta_time,
    input  logic [NICE_W-1:0]    i_nice_index,
    input  logic                 i_is_kernel_thread,
    input  logic [PEN_W-1:0]     i_inherited_penalty,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PEN_W-1:0]     o_penalty_out,
    output logic [SCORE_W-1:0]   o_score_out,
    output logic [PRIO_W-1:0]    o_effective_priority,
    output logic                 o_priority_changed
);

    t_cfg r_cfg;
    logic head_valid, pop, clearing;
    t_req head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset <= OFFSET_RST;
            r_cfg.scale  <= SCALE_RST;
            r_cfg.limit  <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDX_OFFSET: r_cfg.offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_IDX_SCALE:  r_cfg.scale  <= i_cfg_wdata[SCALE_W-1:0];
                CFG_IDX_LIMIT:  r_cfg.limit  <= i_cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bpt_front #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_task_slot         (i_task_slot),
        .i_delta_time        (i_delta_time),
        .i_nice_index        (i_nice_index),
        .i_is_kernel_thread  (i_is_kernel_thread),
        .i_inherited_penalty (i_inherited_penalty),
        .i_clearing          (clearing),
        .o_head_valid        (head_valid),
        .o_head              (head),
        .i_pop               (pop)
    );

    bpt_back #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_head_valid         (head_valid),
        .i_head               (head),
        .o_pop                (pop),
        .o_clearing           (clearing),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_penalty_out        (o_penalty_out),
        .o_score_out          (o_score_out),
        .o_effective_priority (o_effective_priority),
        .o_priority_changed   (o_priority_changed)
    );

endmodule
